[sv/framed_packet_parser_crc16_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Shared helpers that wrap a clocked, reset-qualified property.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_CRC16_UNIT_MACROS_SVH
`define FRAMED_PACKET_PARSER_CRC16_UNIT_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define FPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framed parser: same-cycle check failed");

// check the consequent in the cycle after the antecedent
`define FPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framed parser: next-cycle check failed");

`endif

[sv/fpp_pkg.sv]
// ----------------------------------------------------------------------------
// fpp_pkg
// Types, constants and the CRC-16-CCITT byte update shared by the parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int LEN_W           = 7;
	localparam int CFG_W           = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int CNT_W           = 32;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [31:0] MAGIC_RESET   = 32'h534C5652;
	localparam logic [7:0]  VERSION_RESET = 8'h01;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd1;

	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_MAGIC2  = 4'd2,
		PH_MAGIC3  = 4'd3,
		PH_VERSION = 4'd4,
		PH_TYPE    = 4'd5,
		PH_FLAGS   = 4'd6,
		PH_SEQ     = 4'd7,
		PH_LENH    = 4'd8,
		PH_LENL    = 4'd9,
		PH_PAYLOAD = 4'd10,
		PH_CRCH    = 4'd11,
		PH_CRCL    = 4'd12
	} phase_t;

	typedef enum logic {
		DLV_IDLE = 1'b0,
		DLV_RUN  = 1'b1
	} dlv_state_t;

	// what the beat just taken did to the parser
	typedef struct packed {
		logic take;
		logic good;
		logic bad;
		logic zero_len;
	} parse_evt_t;

	typedef struct packed {
		logic [7:0]       msg_type;
		logic [7:0]       flags;
		logic [7:0]       seq;
		logic [LEN_W-1:0] len;
	} hdr_t;

	function automatic logic [15:0] crc16_update(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

[sv/framed_packet_parser_crc16_unit.sv]
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16_unit
// Framed byte-stream parser with CRC-16-CCITT check and buffered delivery.
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// Output channel: one result beat per out_valid/out_ready handshake.
// Configuration: cfg_we with cfg_index 0 (magic word) or 1 (version byte);
// write only while no result is outstanding.
// Every byte that does not close a good frame gives one status beat, in the
// output register in the cycle after the byte is taken; bytes are taken one per
// cycle while the output is drained. A byte that closes a good frame with L
// payload bytes starts a delivery run out of the payload RAM: the first beat
// comes through the RAM read register and the output register, then one
// beat per cycle, L beats in all. An empty good frame gives a single beat in the
// cycle after the byte, like a status beat. The single RAM read port sets the
// pace of a run; no input is taken until the last beat is loaded.
// When the receiver stalls, the output register holds its beat and in_ready
// drops until the slot frees; a run pauses with the read word held.
// Reset empties the output, returns the parser to sync hunt, clears the
// counters and restores the default magic word and version.
// The payload RAM needs no clearing: only entries of the current frame are read.
// ----------------------------------------------------------------------------
`include "framed_packet_parser_crc16_unit_macros.svh"

module framed_packet_parser_crc16_unit #(
	parameter int MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpp_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           frame_out,
	output logic [7:0]                     msg_type,
	output logic [7:0]                     frame_flags,
	output logic [7:0]                     sequence_res,
	output logic [fpp_pkg::LEN_W-1:0]      payload_length,
	output logic [7:0]                     payload_byte,
	output logic                           byte_valid,
	output logic                           last,
	output logic                           crc_error,
	output logic [fpp_pkg::CNT_W-1:0]      dropped_count,
	output logic [fpp_pkg::CNT_W-1:0]      crc_error_count,
	output logic [fpp_pkg::CNT_W-1:0]      frame_count
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	fpp_pkg::parse_evt_t evt;
	fpp_pkg::hdr_t       hdr;

	logic          take;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	assign take = in_valid && in_ready;

	fpp_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.take         (take),
		.rx_byte      (rx_byte),
		.evt          (evt),
		.hdr          (hdr),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.drop_cnt     (dropped_count),
		.crc_fail_cnt (crc_error_count),
		.good_cnt     (frame_count)
	);

	fpp_payload_ram #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fpp_deliver #(
		.AW (AW)
	) u_deliver (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt            (evt),
		.hdr            (hdr),
		.ram_rdata      (ram_rdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.in_ready       (in_ready),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.frame_out      (frame_out),
		.msg_type       (msg_type),
		.frame_flags    (frame_flags),
		.sequence_res   (sequence_res),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.crc_error      (crc_error)
	);

	// status beats stand alone
	`FPP_ASSERT_NOW(a_status_single, out_valid && !frame_out, last && !byte_valid)
	// a bad-CRC beat is never part of a delivery run
	`FPP_ASSERT_NOW(a_crcerr_no_frame, out_valid && crc_error, !frame_out)
	// a run continues without a gap once a non-final beat is taken
	`FPP_ASSERT_NEXT(a_run_no_gap, out_valid && out_ready && !last, out_valid && frame_out)
	// counters move only on a taken input beat
	`FPP_ASSERT_NEXT(a_cnt_hold, !take,
		$stable(dropped_count) && $stable(crc_error_count) && $stable(frame_count))

endmodule

[sv/fpp_payload_ram.sv]
// ----------------------------------------------------------------------------
// fpp_payload_ram
// Payload buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fpp_payload_ram #(
	parameter int DEPTH = fpp_pkg::MAX_PAYLOAD_DEF,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/fpp_parser.sv]
// ----------------------------------------------------------------------------
// fpp_parser
// Byte-wise frame parser: sync hunt, header capture, running CRC, counters.
// ----------------------------------------------------------------------------
module fpp_parser #(
	parameter int MAX_PAYLOAD = fpp_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpp_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           take,
	input  logic [7:0]                     rx_byte,
	output fpp_pkg::parse_evt_t            evt,
	output fpp_pkg::hdr_t                  hdr,
	output logic                           ram_we,
	output logic [AW-1:0]                  ram_waddr,
	output logic [7:0]                     ram_wdata,
	output logic [fpp_pkg::CNT_W-1:0]      drop_cnt,
	output logic [fpp_pkg::CNT_W-1:0]      crc_fail_cnt,
	output logic [fpp_pkg::CNT_W-1:0]      good_cnt
);

	localparam int LW = fpp_pkg::LEN_W;
	localparam int CW = fpp_pkg::CNT_W;
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	fpp_pkg::phase_t phase_q, phase_n, phase_d;

	logic [31:0]   magic_q;
	logic [7:0]    version_q;
	logic [7:0]    type_q, type_d;
	logic [7:0]    flags_q, flags_d;
	logic [7:0]    seq_q, seq_d;
	logic [15:0]   length_q, length_d;
	logic [LW-1:0] idx_q, idx_d, idx_next;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    rx_crc_hi_q, rx_crc_hi_d;
	logic [CW-1:0] drop_q, crc_fail_q, good_q;
	logic [2:0]    drops;
	logic          good, bad;
	logic [7:0]    mb [4];
	logic [15:0]   len_full;
	logic          crc_match;

	assign mb[0]     = magic_q[31:24];
	assign mb[1]     = magic_q[23:16];
	assign mb[2]     = magic_q[15:8];
	assign mb[3]     = magic_q[7:0];
	assign len_full  = {length_q[15:8], rx_byte};
	assign idx_next  = idx_q + 1'b1;
	assign crc_match = ({rx_crc_hi_q, rx_byte} == crc_q);

	// next phase
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			fpp_pkg::PH_MAGIC0: begin
				if (rx_byte == mb[0]) phase_n = fpp_pkg::PH_MAGIC1;
			end
			fpp_pkg::PH_MAGIC1: begin
				if (rx_byte == mb[1]) phase_n = fpp_pkg::PH_MAGIC2;
				else if (rx_byte != mb[0]) phase_n = fpp_pkg::PH_MAGIC0;
			end
			fpp_pkg::PH_MAGIC2: begin
				phase_n = (rx_byte == mb[2]) ? fpp_pkg::PH_MAGIC3 : fpp_pkg::PH_MAGIC0;
			end
			fpp_pkg::PH_MAGIC3: begin
				phase_n = (rx_byte == mb[3]) ? fpp_pkg::PH_VERSION : fpp_pkg::PH_MAGIC0;
			end
			fpp_pkg::PH_VERSION: begin
				phase_n = (rx_byte == version_q) ? fpp_pkg::PH_TYPE : fpp_pkg::PH_MAGIC0;
			end
			fpp_pkg::PH_TYPE:  phase_n = fpp_pkg::PH_FLAGS;
			fpp_pkg::PH_FLAGS: phase_n = fpp_pkg::PH_SEQ;
			fpp_pkg::PH_SEQ:   phase_n = fpp_pkg::PH_LENH;
			fpp_pkg::PH_LENH:  phase_n = fpp_pkg::PH_LENL;
			fpp_pkg::PH_LENL: begin
				if (len_full > MAX_LEN) phase_n = fpp_pkg::PH_MAGIC0;
				else if (len_full == 16'h0000) phase_n = fpp_pkg::PH_CRCH;
				else phase_n = fpp_pkg::PH_PAYLOAD;
			end
			fpp_pkg::PH_PAYLOAD: begin
				if ({9'd0, idx_next} >= length_q) phase_n = fpp_pkg::PH_CRCH;
			end
			fpp_pkg::PH_CRCH: phase_n = fpp_pkg::PH_CRCL;
			fpp_pkg::PH_CRCL: phase_n = fpp_pkg::PH_MAGIC0;
			default:          phase_n = fpp_pkg::PH_MAGIC0;
		endcase
		phase_d = take ? phase_n : phase_q;
	end

	// datapath updates for the beat in hand
	always_comb begin
		type_d      = type_q;
		flags_d     = flags_q;
		seq_d       = seq_q;
		length_d    = length_q;
		idx_d       = idx_q;
		crc_d       = crc_q;
		rx_crc_hi_d = rx_crc_hi_q;
		drops       = 3'd0;
		good        = 1'b0;
		bad         = 1'b0;
		unique case (phase_q)
			fpp_pkg::PH_MAGIC0: begin
				if (rx_byte != mb[0]) drops = 3'd1;
			end
			fpp_pkg::PH_MAGIC1: begin
				if (rx_byte != mb[1]) drops = (rx_byte == mb[0]) ? 3'd1 : 3'd2;
			end
			fpp_pkg::PH_MAGIC2: begin
				if (rx_byte != mb[2]) drops = 3'd3;
			end
			fpp_pkg::PH_MAGIC3: begin
				if (rx_byte != mb[3]) drops = 3'd4;
			end
			fpp_pkg::PH_VERSION: begin
				if (rx_byte == version_q) crc_d = fpp_pkg::crc16_update(fpp_pkg::CRC_INIT, rx_byte);
				else drops = 3'd1;
			end
			fpp_pkg::PH_TYPE: begin
				type_d = rx_byte;
				crc_d  = fpp_pkg::crc16_update(crc_q, rx_byte);
			end
			fpp_pkg::PH_FLAGS: begin
				flags_d = rx_byte;
				crc_d   = fpp_pkg::crc16_update(crc_q, rx_byte);
			end
			fpp_pkg::PH_SEQ: begin
				seq_d = rx_byte;
				crc_d = fpp_pkg::crc16_update(crc_q, rx_byte);
			end
			fpp_pkg::PH_LENH: begin
				length_d = {rx_byte, 8'h00};
				crc_d    = fpp_pkg::crc16_update(crc_q, rx_byte);
			end
			fpp_pkg::PH_LENL: begin
				length_d = len_full;
				crc_d    = fpp_pkg::crc16_update(crc_q, rx_byte);
				if (len_full > MAX_LEN) drops = 3'd1;
				else idx_d = '0;
			end
			fpp_pkg::PH_PAYLOAD: begin
				crc_d = fpp_pkg::crc16_update(crc_q, rx_byte);
				idx_d = idx_next;
			end
			fpp_pkg::PH_CRCH: rx_crc_hi_d = rx_byte;
			fpp_pkg::PH_CRCL: begin
				good = crc_match;
				bad  = !crc_match;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fpp_pkg::PH_MAGIC0;
			type_q      <= '0;
			flags_q     <= '0;
			seq_q       <= '0;
			length_q    <= '0;
			idx_q       <= '0;
			crc_q       <= fpp_pkg::CRC_INIT;
			rx_crc_hi_q <= '0;
			drop_q      <= '0;
			crc_fail_q  <= '0;
			good_q      <= '0;
		end else begin
			phase_q <= phase_d;
			if (take) begin
				type_q      <= type_d;
				flags_q     <= flags_d;
				seq_q       <= seq_d;
				length_q    <= length_d;
				idx_q       <= idx_d;
				crc_q       <= crc_d;
				rx_crc_hi_q <= rx_crc_hi_d;
				drop_q      <= drop_q + CW'(drops);
				crc_fail_q  <= crc_fail_q + CW'(bad);
				good_q      <= good_q + CW'(good);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= fpp_pkg::MAGIC_RESET;
			version_q <= fpp_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fpp_pkg::REG_MAGIC:   magic_q   <= cfg_wdata;
				fpp_pkg::REG_VERSION: version_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign evt.take     = take;
	assign evt.good     = good;
	assign evt.bad      = bad;
	assign evt.zero_len = (length_q == 16'h0000);

	assign hdr.msg_type = type_q;
	assign hdr.flags    = flags_q;
	assign hdr.seq      = seq_q;
	assign hdr.len      = length_q[LW-1:0];

	assign ram_we    = take && (phase_q == fpp_pkg::PH_PAYLOAD);
	assign ram_waddr = idx_q[AW-1:0];
	assign ram_wdata = rx_byte;

	assign drop_cnt     = drop_q;
	assign crc_fail_cnt = crc_fail_q;
	assign good_cnt     = good_q;

endmodule

[sv/fpp_deliver.sv]
// ----------------------------------------------------------------------------
// fpp_deliver
// Result sequencer: status beats, frame delivery runs from the payload RAM,
// and the output register.
// ----------------------------------------------------------------------------
module fpp_deliver #(
	parameter int AW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fpp_pkg::parse_evt_t        evt,
	input  fpp_pkg::hdr_t              hdr,
	input  logic [7:0]                 ram_rdata,
	output logic                       ram_re,
	output logic [AW-1:0]              ram_raddr,
	output logic                       in_ready,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic                       frame_out,
	output logic [7:0]                 msg_type,
	output logic [7:0]                 frame_flags,
	output logic [7:0]                 sequence_res,
	output logic [fpp_pkg::LEN_W-1:0]  payload_length,
	output logic [7:0]                 payload_byte,
	output logic                       byte_valid,
	output logic                       last,
	output logic                       crc_error
);

	localparam int LW = fpp_pkg::LEN_W;

	fpp_pkg::dlv_state_t state_q, state_d;

	logic          out_valid_q, out_frame_q, out_bvalid_q, out_last_q, out_crcerr_q;
	logic [7:0]    out_byte_q;
	logic [AW-1:0] rd_addr_s1;
	logic          out_free, run_start, is_last;
	logic          load, ld_frame, ld_bvalid, ld_last, ld_crcerr;
	logic [7:0]    ld_byte;

	assign out_free  = !out_valid_q || out_ready;
	assign run_start = evt.take && evt.good && !evt.zero_len;
	assign is_last   = ((LW'(rd_addr_s1) + 1'b1) == hdr.len);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpp_pkg::DLV_IDLE: if (run_start) state_d = fpp_pkg::DLV_RUN;
			fpp_pkg::DLV_RUN:  if (out_free && is_last) state_d = fpp_pkg::DLV_IDLE;
			default:           state_d = fpp_pkg::DLV_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rd_addr_s1 + 1'b1;
		load      = 1'b0;
		ld_frame  = 1'b0;
		ld_byte   = 8'h00;
		ld_bvalid = 1'b0;
		ld_last   = 1'b1;
		ld_crcerr = 1'b0;
		unique case (state_q)
			fpp_pkg::DLV_IDLE: begin
				in_ready  = out_free;
				// a good frame with payload starts its run with a read of entry zero
				ram_re    = run_start;
				ram_raddr = '0;
				load      = evt.take && !run_start;
				ld_frame  = evt.good;
				ld_crcerr = evt.bad;
			end
			fpp_pkg::DLV_RUN: begin
				// stall: keep the read word until the output slot frees
				load      = out_free;
				ram_re    = out_free && !is_last;
				ld_frame  = 1'b1;
				ld_byte   = ram_rdata;
				ld_bvalid = 1'b1;
				ld_last   = is_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpp_pkg::DLV_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_frame_q  <= ld_frame;
			out_byte_q   <= ld_byte;
			out_bvalid_q <= ld_bvalid;
			out_last_q   <= ld_last;
			out_crcerr_q <= ld_crcerr;
		end
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
		end
	end

	// header only changes on a taken beat, which also replaces the held result
	assign out_valid      = out_valid_q;
	assign frame_out      = out_frame_q;
	assign msg_type       = out_frame_q ? hdr.msg_type : 8'h00;
	assign frame_flags    = out_frame_q ? hdr.flags : 8'h00;
	assign sequence_res   = out_frame_q ? hdr.seq : 8'h00;
	assign payload_length = out_frame_q ? hdr.len : '0;
	assign payload_byte   = out_byte_q;
	assign byte_valid     = out_bvalid_q;
	assign last           = out_last_q;
	assign crc_error      = out_crcerr_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet parser testbench
// Feeds a byte stream of good, damaged and noisy frames under four magic and
// version settings, predicts every status and delivery beat in a scoreboard
// and compares each beat taken from the block field by field.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic                      frame;
		logic [7:0]                msg_type;
		logic [7:0]                flags;
		logic [7:0]                seq;
		logic [fpp_pkg::LEN_W-1:0] len;
		logic [7:0]                data;
		logic                      data_ok;
		logic                      last;
		logic                      crc_bad;
		logic [fpp_pkg::CNT_W-1:0] drops;
		logic [fpp_pkg::CNT_W-1:0] crc_fails;
		logic [fpp_pkg::CNT_W-1:0] frames;
	} result_beat_t;

	typedef enum {
		FR_GOOD,
		FR_BAD_CRC,
		FR_LONG,
		FR_BAD_VERSION,
		FR_BAD_MAGIC,
		FR_NOISE
	} frame_kind_t;

	class frame_tracker_t;
		logic [31:0]               magic;
		logic [7:0]                version;
		fpp_pkg::phase_t           phase;
		logic [7:0]                hdr_type;
		logic [7:0]                hdr_flags;
		logic [7:0]                hdr_seq;
		logic [15:0]               len;
		logic [6:0]                idx;
		logic [7:0]                store [64];
		logic [15:0]               crc;
		logic [15:0]               rxcrc;
		logic [fpp_pkg::CNT_W-1:0] drops;
		logic [fpp_pkg::CNT_W-1:0] crc_fails;
		logic [fpp_pkg::CNT_W-1:0] good_frames;
		result_beat_t              due[$];
		int                        bytes_taken;
		int                        beats_seen;
		int                        errors;

		function new();
			magic = fpp_pkg::MAGIC_RESET;
			version = fpp_pkg::VERSION_RESET;
			phase = fpp_pkg::PH_MAGIC0;
			hdr_type = '0;
			hdr_flags = '0;
			hdr_seq = '0;
			len = '0;
			idx = '0;
			foreach (store[i]) store[i] = '0;
			crc = fpp_pkg::CRC_INIT;
			rxcrc = '0;
			drops = '0;
			crc_fails = '0;
			good_frames = '0;
			bytes_taken = 0;
			beats_seen = 0;
			errors = 0;
		endfunction

		// MSB first, one bit per step, no final xor
		static function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0} ^ (fb ? fpp_pkg::CRC_POLY : 16'h0000);
			end
			return c;
		endfunction

		function logic [7:0] magic_at(int k);
			return magic[31 - 8 * k -: 8];
		endfunction

		function void set_reg(logic [fpp_pkg::CFG_IDX_W-1:0] sel,
				logic [fpp_pkg::CFG_W-1:0] value);
			case (sel)
				fpp_pkg::REG_MAGIC:   magic = value;
				fpp_pkg::REG_VERSION: version = value[7:0];
				default:              ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			result_beat_t beat;
			bit           delivered;
			bit           crc_bad;
			int           n;
			delivered = 0;
			crc_bad = 0;
			bytes_taken++;
			case (phase)
				fpp_pkg::PH_MAGIC0: begin
					if (b == magic_at(0)) phase = fpp_pkg::PH_MAGIC1;
					else drops += 1;
				end
				fpp_pkg::PH_MAGIC1: begin
					if (b == magic_at(1)) begin
						phase = fpp_pkg::PH_MAGIC2;
					end else if (b == magic_at(0)) begin
						drops += 1;
					end else begin
						phase = fpp_pkg::PH_MAGIC0;
						drops += 2;
					end
				end
				fpp_pkg::PH_MAGIC2: begin
					if (b == magic_at(2)) begin
						phase = fpp_pkg::PH_MAGIC3;
					end else begin
						phase = fpp_pkg::PH_MAGIC0;
						drops += 3;
					end
				end
				fpp_pkg::PH_MAGIC3: begin
					if (b == magic_at(3)) begin
						phase = fpp_pkg::PH_VERSION;
					end else begin
						phase = fpp_pkg::PH_MAGIC0;
						drops += 4;
					end
				end
				fpp_pkg::PH_VERSION: begin
					if (b == version) begin
						crc = crc16_byte(fpp_pkg::CRC_INIT, b);
						phase = fpp_pkg::PH_TYPE;
					end else begin
						phase = fpp_pkg::PH_MAGIC0;
						drops += 1;
					end
				end
				fpp_pkg::PH_TYPE: begin
					hdr_type = b;
					crc = crc16_byte(crc, b);
					phase = fpp_pkg::PH_FLAGS;
				end
				fpp_pkg::PH_FLAGS: begin
					hdr_flags = b;
					crc = crc16_byte(crc, b);
					phase = fpp_pkg::PH_SEQ;
				end
				fpp_pkg::PH_SEQ: begin
					hdr_seq = b;
					crc = crc16_byte(crc, b);
					phase = fpp_pkg::PH_LENH;
				end
				fpp_pkg::PH_LENH: begin
					len = {b, 8'h00};
					crc = crc16_byte(crc, b);
					phase = fpp_pkg::PH_LENL;
				end
				fpp_pkg::PH_LENL: begin
					len = {len[15:8], b};
					crc = crc16_byte(crc, b);
					if (len > 16'(fpp_pkg::MAX_PAYLOAD_DEF)) begin
						phase = fpp_pkg::PH_MAGIC0;
						drops += 1;
					end else begin
						idx = '0;
						phase = (len == 16'd0) ? fpp_pkg::PH_CRCH : fpp_pkg::PH_PAYLOAD;
					end
				end
				fpp_pkg::PH_PAYLOAD: begin
					store[idx[5:0]] = b;
					crc = crc16_byte(crc, b);
					idx = idx + 7'd1;
					if ({9'd0, idx} >= len) phase = fpp_pkg::PH_CRCH;
				end
				fpp_pkg::PH_CRCH: begin
					rxcrc = {b, 8'h00};
					phase = fpp_pkg::PH_CRCL;
				end
				fpp_pkg::PH_CRCL: begin
					rxcrc = {rxcrc[15:8], b};
					phase = fpp_pkg::PH_MAGIC0;
					if (rxcrc == crc) begin
						good_frames += 1;
						delivered = 1;
					end else begin
						crc_fails += 1;
						crc_bad = 1;
					end
				end
				default: phase = fpp_pkg::PH_MAGIC0;
			endcase

			if (delivered) begin
				n = (len == 16'd0) ? 1 : int'(len);
				for (int k = 0; k < n; k++) begin
					beat.frame = 1'b1;
					beat.msg_type = hdr_type;
					beat.flags = hdr_flags;
					beat.seq = hdr_seq;
					beat.len = len[fpp_pkg::LEN_W-1:0];
					beat.data = (len == 16'd0) ? 8'h00 : store[k];
					beat.data_ok = (len != 16'd0);
					beat.last = (k == n - 1);
					beat.crc_bad = 1'b0;
					beat.drops = drops;
					beat.crc_fails = crc_fails;
					beat.frames = good_frames;
					due.push_back(beat);
				end
			end else begin
				beat = '0;
				beat.last = 1'b1;
				beat.crc_bad = crc_bad;
				beat.drops = drops;
				beat.crc_fails = crc_fails;
				beat.frames = good_frames;
				due.push_back(beat);
			end
		endfunction

		function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void match_beat(result_beat_t got);
			result_beat_t want;
			int           bad;
			beats_seen++;
			if (due.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %h", $time, got);
				errors++;
				return;
			end
			want = due.pop_front();
			bad = 0;
			bad += field_differs("frame_out", want.frame, got.frame);
			bad += field_differs("msg_type", want.msg_type, got.msg_type);
			bad += field_differs("frame_flags", want.flags, got.flags);
			bad += field_differs("sequence_res", want.seq, got.seq);
			bad += field_differs("payload_length", want.len, got.len);
			bad += field_differs("payload_byte", want.data, got.data);
			bad += field_differs("byte_valid", want.data_ok, got.data_ok);
			bad += field_differs("last", want.last, got.last);
			bad += field_differs("crc_error", want.crc_bad, got.crc_bad);
			bad += field_differs("dropped_count", want.drops, got.drops);
			bad += field_differs("crc_error_count", want.crc_fails, got.crc_fails);
			bad += field_differs("frame_count", want.frames, got.frames);
			if (bad != 0) errors++;
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fpp_pkg::CFG_W-1:0]     cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [7:0]                    rx_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic                          frame_out;
	logic [7:0]                    msg_type;
	logic [7:0]                    frame_flags;
	logic [7:0]                    sequence_res;
	logic [fpp_pkg::LEN_W-1:0]     payload_length;
	logic [7:0]                    payload_byte;
	logic                          byte_valid;
	logic                          last;
	logic                          crc_error;
	logic [fpp_pkg::CNT_W-1:0]     dropped_count;
	logic [fpp_pkg::CNT_W-1:0]     crc_error_count;
	logic [fpp_pkg::CNT_W-1:0]     frame_count;

	frame_tracker_t tracker = new();
	bit             squeeze_rx;
	int             tx_run_left;

	framed_packet_parser_crc16_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_out       (frame_out),
		.msg_type        (msg_type),
		.frame_flags     (frame_flags),
		.sequence_res    (sequence_res),
		.payload_length  (payload_length),
		.payload_byte    (payload_byte),
		.byte_valid      (byte_valid),
		.last            (last),
		.crc_error       (crc_error),
		.dropped_count   (dropped_count),
		.crc_error_count (crc_error_count),
		.frame_count     (frame_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.match_beat(result_beat_t'({frame_out, msg_type, frame_flags,
				sequence_res, payload_length, payload_byte, byte_valid, last,
				crc_error, dropped_count, crc_error_count, frame_count}));
		end
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (tx_run_left > 0) begin
			tx_run_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 15) == 0) tx_run_left = $urandom_range(8, 32);
			gap = $urandom_range(0, 8);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b);
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int plen);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		logic [15:0] flen;
		int          k;
		for (k = 0; k < 4; k++) fb.push_back(tracker.magic_at(k));
		fb.push_back(tracker.version);
		if (kind == FR_NOISE) begin
			fb.delete();
			repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
		end else if (kind == FR_BAD_MAGIC) begin
			k = $urandom_range(1, 3);
			fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
			while (fb.size() > k + 1) void'(fb.pop_back());
		end else if (kind == FR_BAD_VERSION) begin
			fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
		end else begin
			if (kind == FR_LONG) begin
				case ($urandom_range(0, 2))
					0:       flen = 16'(fpp_pkg::MAX_PAYLOAD_DEF + 1);
					1:       flen = 16'hFFFF;
					default: begin
						flen = 16'($urandom_range(fpp_pkg::MAX_PAYLOAD_DEF + 1, 65535));
					end
				endcase
			end else begin
				flen = 16'(plen);
			end
			repeat (3) fb.push_back(8'($urandom));
			fb.push_back(flen[15:8]);
			fb.push_back(flen[7:0]);
			if (kind != FR_LONG) begin
				repeat (plen) fb.push_back(8'($urandom));
				crc = fpp_pkg::CRC_INIT;
				for (k = 4; k < fb.size(); k++) crc = frame_tracker_t::crc16_byte(crc, fb[k]);
				if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
				fb.push_back(crc[15:8]);
				fb.push_back(crc[7:0]);
			end
		end
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	task automatic run_random(input int budget);
		int          first;
		int          pick;
		int          plen;
		frame_kind_t kind;
		first = tracker.bytes_taken;
		while (tracker.bytes_taken - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) kind = FR_GOOD;
			else if (pick < 65) kind = FR_BAD_CRC;
			else if (pick < 75) kind = FR_LONG;
			else if (pick < 85) kind = FR_BAD_VERSION;
			else if (pick < 95) kind = FR_BAD_MAGIC;
			else kind = FR_NOISE;
			// mostly short payloads, now and then a long one
			if ($urandom_range(0, 15) == 0) plen = $urandom_range(9, fpp_pkg::MAX_PAYLOAD_DEF);
			else plen = $urandom_range(0, 8);
			send_frame(kind, plen);
		end
	endtask

	// drop valid and wait for every predicted beat to drain
	task automatic settle(input int tail);
		in_valid <= 1'b0;
		while (tracker.due.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic program_regs(input logic [fpp_pkg::CFG_W-1:0] magic_data,
			input logic [fpp_pkg::CFG_W-1:0] version_data);
		cfg_we <= 1'b1;
		cfg_index <= fpp_pkg::REG_MAGIC;
		cfg_wdata <= magic_data;
		@(negedge clk);
		tracker.set_reg(fpp_pkg::REG_MAGIC, magic_data);
		cfg_index <= fpp_pkg::REG_VERSION;
		cfg_wdata <= version_data;
		@(negedge clk);
		tracker.set_reg(fpp_pkg::REG_VERSION, version_data);
		cfg_we <= 1'b0;
	endtask

	initial begin : drain
		int gap;
		int run_left;
		bit squeezed;
		out_ready = 1'b0;
		run_left = 0;
		squeezed = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (squeeze_rx && !squeezed) begin
				// hold off long enough for the block to back up into its input
				squeezed = 1;
				gap = 160;
			end else if (run_left > 0) begin
				run_left--;
				gap = 0;
			end else begin
				if ($urandom_range(0, 15) == 0) run_left = $urandom_range(8, 32);
				gap = $urandom_range(0, 8);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d beats still expected", tracker.due.size());
		$display("testbench: errors");
		$finish;
	end

	initial begin
		logic [7:0] m[4];
		logic [7:0] opening[$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fpp_pkg::REG_MAGIC;
		cfg_wdata = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		squeeze_rx = 0;
		tx_run_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// hunt and reject cases under the default sync word and version
		for (int k = 0; k < 4; k++) m[k] = tracker.magic_at(k);
		opening = {8'h00, m[0], m[0], m[1], m[2], m[3], fpp_pkg::VERSION_RESET + 8'd1,
			m[0], 8'h00, m[0], m[1], 8'h00, m[0], m[1], m[2], 8'hFF};
		foreach (opening[i]) send_byte(opening[i]);
		send_frame(FR_GOOD, 0);
		settle(6);

		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_random(12);
		settle(6);

		program_regs(32'h0000_0000, 32'h0000_0000);
		run_random(12);
		settle(6);

		program_regs($urandom, $urandom);
		run_random(12);
		settle(6);

		program_regs(fpp_pkg::MAGIC_RESET, {24'($urandom), fpp_pkg::VERSION_RESET});
		squeeze_rx = 1;
		send_frame(FR_GOOD, fpp_pkg::MAX_PAYLOAD_DEF);
		run_random(10);
		settle(20);

		$display("covered %0d stream bytes under four sync word and version settings",
			tracker.bytes_taken);
		$display("%0d beats checked: %0d good frames, %0d CRC failures, %0d bytes dropped",
			tracker.beats_seen, tracker.good_frames, tracker.crc_fails, tracker.drops);
		if (tracker.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

[framed_packet_parser_crc16_unit.f]
+incdir+sv
sv/fpp_pkg.sv
sv/fpp_payload_ram.sv
sv/fpp_parser.sv
sv/fpp_deliver.sv
sv/framed_packet_parser_crc16_unit.sv
tb/testbench.sv
